FILE: rtl/bgt_pkg.sv
// bgt_pkg: shared types and constants for the beat grid table
// no dependencies
package bgt_pkg;
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = IDX_W + 1;

    typedef enum logic [2:0] {
        MODE_CLEAR  = 3'd0,
        MODE_INSERT = 3'd1,
        MODE_UPDATE = 3'd2,
        MODE_TIME   = 3'd3,
        MODE_POS    = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INS_SRCH, S_INS_SRCH_W, S_INS_SHIFT_RD, S_INS_SHIFT_WR, S_INS_PUT,
        S_UPD_PUT,
        S_TQ_RD0, S_TQ_RD0_W, S_TQ_RD1, S_TQ_RD1_W, S_TQ_MUL, S_TQ_ADD,
        S_PQ_FIRST, S_PQ_FIRST_W, S_PQ_LAST, S_PQ_LAST_W,
        S_PQ_SRCH, S_PQ_SRCH_W, S_PQ_DIV, S_DONE
    } t_state;
endpackage

FILE: rtl/bgt_ram.sv
// bgt_ram: generic single port ram with registered read
// no dependencies
module bgt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

FILE: rtl/bgt_div.sv
// bgt_div: restoring divider, one quotient bit per cycle
// uses bgt_pkg
module bgt_div
    import bgt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [48:0] i_num,
    input  logic [32:0] i_den,
    output logic        o_done,
    output logic [15:0] o_quot
);
    logic [48:0] r_num, n_num;
    logic [33:0] r_rem, n_rem;
    logic [32:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [33:0] w_try;

    always_comb begin
        w_try = {r_rem[32:0], r_num[48]};
        n_num = {r_num[47:0], 1'b0};
        n_rem = w_try;
        if (w_try >= {1'b0, r_den}) begin
            n_rem    = w_try - {1'b0, r_den};
            n_num[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd48) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    // quotient fits 16 bits since t - lo < diff
    assign o_quot = r_num[15:0];
endmodule

FILE: rtl/beat_grid_table_top.sv
// beat_grid_table_top: beat time table with clear, insert and update requests plus time and position queries
// uses bgt_pkg, bgt_ram, bgt_div
// flow per request: clear, spare modes and rejected requests go straight to done;
// update writes once; insert searches then shifts (one memory port), then writes;
// time query reads one entry, or two then multiplies and adds; position query reads
// the first and last entries, searches linearly and may run the divider. one request
// at a time, the next one is taken no earlier than the cycle in which the previous result shows up.
// reset clears the entry count; table contents are undefined until written
module beat_grid_table_top
    import bgt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_mode,
    input  logic signed [31:0] i_time_value,
    input  logic [9:0]  i_entry_index,
    input  logic signed [11:0] i_bar_number,
    input  logic [1:0]  i_beat_in_bar,
    input  logic [15:0] i_beat_fraction,
    input  logic        i_given_in_seconds,
    input  logic        i_position_valid,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [31:0] o_result_time,
    output logic [8:0]  o_result_bar,
    output logic [1:0]  o_result_beat,
    output logic [15:0] o_result_fraction,
    output logic        o_result_position_ok,
    output logic [10:0] o_entry_count,
    output logic [1:0]  o_status
);
    t_state r_state, n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_ptr;
    logic signed [31:0] r_t, r_v0, r_hold;
    logic signed [13:0] r_beat;
    logic [15:0] r_frac;
    logic signed [49:0] r_prod;

    logic          ram_we;
    logic [IDX_W-1:0] ram_addr;
    logic [31:0]   ram_wdata, ram_rdata;
    logic signed [31:0] rd;

    logic        div_start, div_done;
    logic [15:0] div_quot;
    logic [48:0] div_num;
    logic [32:0] div_den;

    logic signed [13:0] w_beat;
    logic signed [32:0] w_diff;

    logic accept;
    assign o_stall = (r_state != S_IDLE) || (o_valid && i_stall);
    assign accept  = i_valid && !o_stall;
    assign rd = ram_rdata;

    bgt_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr),
        .i_wdata(ram_wdata), .o_rdata(ram_rdata)
    );

    bgt_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(div_num), .i_den(div_den), .o_done(div_done), .o_quot(div_quot)
    );

    assign w_beat = 14'({i_bar_number, 2'b00}) + 14'({12'd0, i_beat_in_bar});

    // span between the entry just read and the one below it
    assign w_diff  = 33'(rd) - 33'(r_v0);
    assign div_num = {1'b0, 48'(33'(r_t) - 33'(r_v0)) << 16};
    assign div_den = w_diff;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept) begin
                unique case (i_mode)
                    MODE_INSERT: n_state = (r_count >= CNT_W'(TABLE_DEPTH)) ? S_DONE
                                          : (r_count == '0) ? S_INS_PUT : S_INS_SRCH;
                    MODE_UPDATE: n_state = ({1'b0, i_entry_index} < r_count) ? S_UPD_PUT
                                          : S_DONE;
                    MODE_TIME: n_state = (i_given_in_seconds || !i_position_valid ||
                                          r_count == '0 || w_beat < 0) ? S_DONE : S_TQ_RD0;
                    MODE_POS: n_state = (r_count == '0 || i_time_value < 0) ? S_DONE
                                         : S_PQ_FIRST;
                    default: n_state = S_DONE;
                endcase
            end
            S_INS_SRCH:   n_state = S_INS_SRCH_W;
            S_INS_SRCH_W: begin
                if (!(rd < r_t)) n_state = (r_ptr == r_count) ? S_INS_PUT : S_INS_SHIFT_RD;
                else if (r_ptr + 1'b1 == r_count) n_state = S_INS_PUT;
                else n_state = S_INS_SRCH;
            end
            S_INS_SHIFT_RD: n_state = S_INS_SHIFT_WR;
            S_INS_SHIFT_WR: n_state = (r_hold[CNT_W-1:0] == r_ptr + 1'b1) ? S_INS_PUT
                                       : S_INS_SHIFT_RD;
            S_INS_PUT: n_state = S_DONE;
            S_UPD_PUT: n_state = S_DONE;
            S_TQ_RD0:   n_state = S_TQ_RD0_W;
            S_TQ_RD0_W: n_state = (r_frac == '0 || 32'(r_ptr) + 1 >= 32'(r_count))
                                  ? S_DONE : S_TQ_RD1;
            S_TQ_RD1:   n_state = S_TQ_RD1_W;
            S_TQ_RD1_W: n_state = S_TQ_MUL;
            S_TQ_MUL:   n_state = S_TQ_ADD;
            S_TQ_ADD:   n_state = S_DONE;
            S_PQ_FIRST:   n_state = S_PQ_FIRST_W;
            S_PQ_FIRST_W: n_state = (r_t <= rd) ? S_DONE : S_PQ_LAST;
            S_PQ_LAST:    n_state = S_PQ_LAST_W;
            S_PQ_LAST_W:  n_state = (r_t >= rd) ? S_DONE : S_PQ_SRCH;
            S_PQ_SRCH:    n_state = S_PQ_SRCH_W;
            S_PQ_SRCH_W: begin
                if (rd == r_t) n_state = S_DONE;
                else if (rd > r_t) n_state = (w_diff > 0) ? S_PQ_DIV : S_DONE;
                else n_state = (r_ptr + 1'b1 == r_count) ? S_DONE : S_PQ_SRCH;
            end
            S_PQ_DIV: if (div_done) n_state = S_DONE;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // memory port and divider start
    always_comb begin
        ram_we = 1'b0;
        ram_addr = r_ptr[IDX_W-1:0];
        ram_wdata = r_t;
        div_start = 1'b0;
        unique case (r_state)
            S_INS_SHIFT_RD: ram_addr = IDX_W'(r_hold[CNT_W-1:0] - 1'b1);
            S_INS_SHIFT_WR: begin
                ram_we = 1'b1;
                ram_addr = r_hold[IDX_W-1:0];
                ram_wdata = rd;
            end
            S_INS_PUT: ram_we = 1'b1;
            S_UPD_PUT: ram_we = 1'b1;
            S_PQ_SRCH_W: div_start = (rd > r_t) && (rd != r_t);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE) o_valid <= 1'b1;
            else if (!i_stall) o_valid <= 1'b0;
            if (accept && i_mode == MODE_CLEAR) r_count <= '0;
            else if (r_state == S_INS_PUT) r_count <= r_count + 1'b1;
        end

        unique case (r_state)
            S_IDLE: if (accept) begin
                r_t <= i_time_value;
                r_frac <= i_beat_fraction;
                r_beat <= w_beat;
                o_result_bar <= '0;
                o_result_beat <= '0;
                o_result_fraction <= '0;
                o_result_time <= (i_mode == MODE_TIME && i_given_in_seconds)
                                 ? i_time_value : '0;
                o_result_position_ok <= (i_mode == MODE_POS && r_count != '0 &&
                                         i_time_value >= 0);
                if (i_mode == MODE_INSERT && r_count >= CNT_W'(TABLE_DEPTH))
                    o_status <= ST_FULL;
                else if (i_mode == MODE_UPDATE && {1'b0, i_entry_index} >= r_count)
                    o_status <= ST_RANGE;
                else o_status <= ST_OK;
                if (i_mode == MODE_UPDATE) r_ptr <= {1'b0, i_entry_index};
                else if (i_mode == MODE_TIME && 32'(w_beat) >= 32'(r_count))
                    r_ptr <= r_count - 1'b1;
                else if (i_mode == MODE_TIME) r_ptr <= CNT_W'(w_beat);
                else r_ptr <= '0;
            end
            S_INS_SRCH_W: begin
                r_hold <= 32'(r_count);
                if (rd < r_t) r_ptr <= r_ptr + 1'b1;
            end
            S_INS_SHIFT_WR: r_hold <= r_hold - 1;
            S_TQ_RD0_W: begin
                r_v0 <= rd;
                o_result_time <= rd;
                if (32'(r_beat) >= 32'(r_count)) r_frac <= '0;
                r_ptr <= r_ptr + 1'b1;
            end
            S_TQ_RD1_W: r_prod <= (50'(rd) - 50'(r_v0)) * $signed({1'b0, r_frac});
            S_TQ_MUL: r_prod <= r_prod >>> 16;
            S_TQ_ADD: o_result_time <= r_v0 + r_prod[31:0];
            S_PQ_FIRST_W: begin
                r_v0 <= rd;
                if (r_t > rd) r_ptr <= r_count - 1'b1;
            end
            S_PQ_LAST_W: begin
                if (r_t >= rd) begin
                    o_result_bar <= 9'(r_count >> 2);
                    o_result_beat <= r_count[1:0];
                end
                // search resumes at entry 1, entry 0 already sits in r_v0
                r_ptr <= CNT_W'(1);
            end
            S_PQ_SRCH_W: begin
                if (rd == r_t) begin
                    o_result_bar <= 9'(r_ptr >> 2);
                    o_result_beat <= r_ptr[1:0];
                end else if (rd > r_t) begin
                    o_result_bar <= 9'((r_ptr - 1'b1) >> 2);
                    o_result_beat <= 2'(r_ptr - 1'b1);
                end else begin
                    r_v0 <= rd;
                    r_ptr <= r_ptr + 1'b1;
                    if (r_ptr + 1'b1 == r_count) begin
                        o_result_bar <= 9'(r_count >> 2);
                        o_result_beat <= r_count[1:0];
                    end
                end
            end
            S_PQ_DIV: if (div_done) o_result_fraction <= div_quot;
            default: ;
        endcase
        o_entry_count <= (r_state == S_DONE) ? r_count : o_entry_count;
    end
endmodule

FILE: bench/tb_beat_grid_table_top.sv
// tb_beat_grid_table_top: self-checking bench for the beat grid table
// depends on bgt_pkg and beat_grid_table_top; carries its own table predictor
module tb_beat_grid_table_top
    import bgt_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;
    localparam int DEPTH = 1024;

    typedef struct {
        logic [2:0]  mode;
        logic [31:0] tval;
        logic [9:0]  idx;
        logic [11:0] bar;
        logic [1:0]  beat;
        logic [15:0] frac;
        logic        in_sec;
        logic        pos_ok;
        bit          hold_idle;
    } t_req;

    typedef struct {
        logic [31:0] rtime;
        logic [8:0]  rbar;
        logic [1:0]  rbeat;
        logic [15:0] rfrac;
        logic        rok;
        logic [10:0] cnt;
        logic [1:0]  st;
    } t_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [2:0]  i_mode = '0;
    logic signed [31:0] i_time_value = '0;
    logic [9:0]  i_entry_index = '0;
    logic signed [11:0] i_bar_number = '0;
    logic [1:0]  i_beat_in_bar = '0;
    logic [15:0] i_beat_fraction = '0;
    logic        i_given_in_seconds = 1'b0;
    logic        i_position_valid = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic signed [31:0] o_result_time;
    logic [8:0]  o_result_bar;
    logic [1:0]  o_result_beat;
    logic [15:0] o_result_fraction;
    logic        o_result_position_ok;
    logic [10:0] o_entry_count;
    logic [1:0]  o_status;

    beat_grid_table_top dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor state
    logic [31:0] grid [DEPTH];
    int unsigned grid_cnt = 0;

    t_req    pending_reqs[$];
    t_answer answers_due[$];
    int      errors = 0;
    int      n_acc = 0;
    int      n_done = 0;
    int      mode_seen[8];
    int      full_drops = 0;
    int      range_drops = 0;

    task automatic report(string what, longint got, longint want);
        $display("mismatch on result %0d: %s got %0h want %0h", n_done, what, got, want);
        errors++;
    endtask

    function automatic logic [31:0] lookup_time(t_req r);
        int beat_no;
        longint v0, v1, p;
        if (r.in_sec) return r.tval;
        if (!r.pos_ok || grid_cnt == 0) return '0;
        beat_no = int'($signed(r.bar)) * 4 + int'(r.beat);
        if (beat_no < 0) return '0;
        if (beat_no >= grid_cnt) return grid[grid_cnt-1];
        if (r.frac == 0 || beat_no + 1 >= grid_cnt) return grid[beat_no];
        v0 = longint'($signed(grid[beat_no]));
        v1 = longint'($signed(grid[beat_no+1]));
        p = (v1 - v0) * longint'(r.frac);
        return 32'(v0 + (p >>> 16));
    endfunction

    function automatic void place_pos(ref t_answer a, input int unsigned ix,
                                      input logic [15:0] f);
        a.rbar = 9'(ix / 4);
        a.rbeat = 2'(ix % 4);
        a.rfrac = f;
        a.rok = 1'b1;
    endfunction

    function automatic void locate_beat(ref t_answer a, input logic [31:0] tv);
        int t;
        longint lo, e;
        t = $signed(tv);
        if (grid_cnt == 0 || t < 0) return;
        if (t <= $signed(grid[0])) begin
            place_pos(a, 0, 0);
            return;
        end
        if (t >= $signed(grid[grid_cnt-1])) begin
            place_pos(a, grid_cnt, 0);
            return;
        end
        for (int unsigned i = 1; i < grid_cnt; i++) begin
            e = longint'($signed(grid[i]));
            if (e == t) begin
                place_pos(a, i, 0);
                return;
            end
            if (e > t) begin
                lo = longint'($signed(grid[i-1]));
                place_pos(a, i - 1,
                          (e - lo > 0) ? 16'(((longint'(t) - lo) * 65536) / (e - lo)) : 16'd0);
                return;
            end
        end
        place_pos(a, grid_cnt, 0);
    endfunction

    function automatic t_answer apply_request(t_req r);
        t_answer a;
        int unsigned slot;
        a = '{default: '0};
        a.st = ST_OK;
        case (r.mode)
            MODE_CLEAR: grid_cnt = 0;
            MODE_INSERT: begin
                if (grid_cnt >= DEPTH) begin
                    a.st = ST_FULL;
                end else begin
                    slot = 0;
                    while (slot < grid_cnt && $signed(grid[slot]) < $signed(r.tval)) slot++;
                    for (int unsigned k = grid_cnt; k > slot; k--) grid[k] = grid[k-1];
                    grid[slot] = r.tval;
                    grid_cnt++;
                end
            end
            MODE_UPDATE: begin
                if (r.idx < grid_cnt) grid[r.idx] = r.tval;
                else a.st = ST_RANGE;
            end
            MODE_TIME: a.rtime = lookup_time(r);
            MODE_POS: locate_beat(a, r.tval);
            default: ;
        endcase
        a.cnt = 11'(grid_cnt);
        return a;
    endfunction

    // sender: bursts of random length with random gaps
    int burst_left = 8;
    int gap_left = 0;
    always @(posedge i_clk) begin
        t_req r;
        t_answer a;
        bit took;
        if (i_rst_n) begin
            took = i_valid && !o_stall;
            if (took) begin
                r.mode = i_mode; r.tval = i_time_value; r.idx = i_entry_index;
                r.bar = i_bar_number; r.beat = i_beat_in_bar; r.frac = i_beat_fraction;
                r.in_sec = i_given_in_seconds; r.pos_ok = i_position_valid;
                a = apply_request(r);
                if (a.st == ST_FULL) full_drops++;
                if (a.st == ST_RANGE) range_drops++;
                mode_seen[r.mode]++;
                answers_due.insert(answers_due.size(), a);
                n_acc++;
            end
            if (!i_valid || took) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_reqs.size() > 0 &&
                             !(pending_reqs[0].hold_idle && (took || n_acc != n_done))) begin
                    r = pending_reqs.pop_front();
                    i_valid <= 1'b1;
                    i_mode <= r.mode; i_time_value <= r.tval; i_entry_index <= r.idx;
                    i_bar_number <= r.bar; i_beat_in_bar <= r.beat;
                    i_beat_fraction <= r.frac; i_given_in_seconds <= r.in_sec;
                    i_position_valid <= r.pos_ok;
                    if (--burst_left <= 0) begin
                        burst_left = $urandom_range(1, 30);
                        gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall rate is re-picked at random from none, 30 and 80 percent
    int stall_pct = 0;
    int stall_tick = 0;
    always @(posedge i_clk) begin
        t_answer w;
        stall_tick++;
        if (stall_tick % 64 == 0) begin
            case ($urandom_range(0, 2))
                0: stall_pct = 0;
                1: stall_pct = 30;
                default: stall_pct = 80;
            endcase
        end
        i_stall <= ($urandom_range(0, 99) < stall_pct);
        if (i_rst_n && o_valid && !i_stall) begin
            if (answers_due.size() == 0) begin
                $display("unexpected result with nothing outstanding");
                errors++;
            end else begin
                w = answers_due.pop_front();
                if (o_result_time !== w.rtime) report("time", o_result_time, w.rtime);
                if (o_result_bar !== w.rbar) report("bar", o_result_bar, w.rbar);
                if (o_result_beat !== w.rbeat) report("beat", o_result_beat, w.rbeat);
                if (o_result_fraction !== w.rfrac)
                    report("fraction", o_result_fraction, w.rfrac);
                if (o_result_position_ok !== w.rok)
                    report("position_ok", o_result_position_ok, w.rok);
                if (o_entry_count !== w.cnt) report("entry_count", o_entry_count, w.cnt);
                if (o_status !== w.st) report("status", o_status, w.st);
            end
            n_done <= n_done + 1;
        end
    end

    // stimulus building
    int unsigned plan_cnt = 0;

    function automatic void add(logic [2:0] m, logic [31:0] tv, logic [9:0] ix = 0,
                                logic [11:0] b = 0, logic [1:0] bt = 0,
                                logic [15:0] f = 0, logic s = 0, logic pv = 1,
                                bit hold = 0);
        t_req r;
        r = '{m, tv, ix, b, bt, f, s, pv, hold};
        pending_reqs.insert(pending_reqs.size(), r);
        if (m == MODE_CLEAR) plan_cnt = 0;
        else if (m == MODE_INSERT && plan_cnt < DEPTH) plan_cnt++;
    endfunction

    function automatic logic [31:0] rand_time();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 8) << 16;
            default: return $urandom_range(0, 32'h0010_0000);
        endcase
    endfunction

    function automatic void add_random();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5 || plan_cnt > 40) add(MODE_CLEAR, $urandom());
        else if (pick < 45) add(MODE_INSERT, rand_time(), 10'($urandom()));
        else if (pick < 58)
            add(MODE_UPDATE, rand_time(),
                ($urandom_range(0, 4) == 0 || plan_cnt == 0) ?
                    10'($urandom()) : 10'($urandom_range(0, plan_cnt - 1)));
        else if (pick < 78)
            add(MODE_TIME, $urandom(), 10'($urandom()),
                ($urandom_range(0, 4) == 0) ? 12'($urandom()) :
                    12'($signed($urandom_range(0, 14)) - 2),
                2'($urandom()), ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom()),
                $urandom_range(0, 7) == 0, $urandom_range(0, 7) != 0);
        else if (pick < 97) add(MODE_POS, rand_time(), 10'($urandom()));
        else add(3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI)), $urandom(),
                 10'($urandom()), 12'($urandom()), 2'($urandom()), 16'($urandom()),
                 1'($urandom()), 1'($urandom()));
    endfunction

    initial begin
        // directed corners
        add(MODE_POS, 32'h0001_0000);
        add(MODE_TIME, 0, 0, 0, 0, 0, 0, 1);
        add(MODE_INSERT, 32'h7FFF_FFFF);
        add(MODE_INSERT, 32'h8000_0000);
        add(MODE_INSERT, 32'h0002_0000);
        add(MODE_INSERT, 32'h0002_0000);
        add(MODE_INSERT, 32'h0004_0000);
        add(MODE_UPDATE, 32'h0000_0000, 0);
        add(MODE_UPDATE, 32'h1, 10'd1023);
        add(MODE_TIME, 32'hDEAD_BEEF, 0, 0, 0, 0, 1, 1);
        add(MODE_TIME, 0, 0, 0, 1, 16'h8000, 0, 0);
        add(MODE_TIME, 0, 0, 12'h800, 3, 16'hFFFF);
        add(MODE_TIME, 0, 0, 12'h7FF, 3, 16'hFFFF);
        add(MODE_TIME, 0, 0, 0, 2, 0);
        add(MODE_TIME, 0, 0, 0, 3, 16'hFFFF);
        add(MODE_TIME, 0, 0, 0, 2, 16'hFFFF);
        add(MODE_TIME, 0, 0, 1, 0, 16'h0001);
        add(MODE_POS, 32'hFFFF_0000);
        add(MODE_POS, 32'h0000_0000);
        add(MODE_POS, 32'h7FFF_FFFF);
        add(MODE_POS, 32'h0003_0000);
        add(MODE_POS, 32'h0002_0000);
        add(MODE_SPARE_LO, 0);
        // clear only after a full drain, then a single entry table
        add(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 1, 1);
        add(MODE_INSERT, 32'h1);
        add(MODE_UPDATE, 32'h7FFF_0000, 10'd1023);
        add(MODE_TIME, 0, 0, 12'd255, 3, 16'h4000);
        add(MODE_TIME, 0, 0, 12'd255, 2, 16'hFFFF);
        add(MODE_POS, 32'h7FFF_FFFF);
        add(MODE_POS, 32'h0200_0000);
        add(MODE_CLEAR, 0);
        for (int k = 0; k < 510; k++) add_random();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk);
        while (pending_reqs.size() > 0 || i_valid || n_acc != n_done);
        repeat (100) @(posedge i_clk);
        $display("run: %0d requests (clear %0d insert %0d update %0d time %0d position %0d)",
                 n_acc, mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3], mode_seen[4]);
        $display("full-table drops %0d, out-of-range updates %0d, spare modes %0d",
                 full_drops, range_drops, mode_seen[5] + mode_seen[6] + mode_seen[7]);
        if (errors == 0 && answers_due.size() == 0) begin
            $display("beat_grid_table_top verification clean");
        end else begin
            $display("beat_grid_table_top verification failed");
        end
        $finish;
    end

    initial begin
        #100ms;
        $display("beat_grid_table_top verification failed");
        $finish;
    end
endmodule
